@@ rtl/gsa_pkg.sv @@
// Shared operation and status codes for the generational slot allocator.
`default_nettype none

package gsa_pkg;

	// operation codes carried in func
	typedef enum logic [2:0] {
		FUNC_ALLOC    = 3'd0,
		FUNC_FREE     = 3'd1,
		FUNC_VALIDATE = 3'd2,
		FUNC_READ_GEN = 3'd3,
		FUNC_CLEAR    = 3'd4
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_STALE = 2'd2
	} status_t;

	localparam int KIND_BITS = 8;

endpackage

`default_nettype wire

@@ rtl/generational_slot_allocator.sv @@
// Top level of the generational slot allocator: handle table with used bits and generation memory.
`default_nettype none

// At acceptance the slot's generation and kind are read from a synchronous memory
// (the lowest free slot, found by a priority encoder over the used bits, for
// allocate); the word then waits in stage 1 until the output register is free or
// not stalled, and there it is checked, the slot state is updated (on allocate the
// memory word is written back) and the result is loaded into the output register.
// A new word is not taken while stage 1 holds one; a result waiting on a stalled
// output does not block the next acceptance, only the completion of the one after.
// Used bits and generation-valid bits sit in flops, so reset and clear take effect
// at once with no clearing pass.
module generational_slot_allocator
	import gsa_pkg::*;
#(
	parameter int SLOTS    = 64,
	parameter int GEN_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output      logic                         req_stall,
	input  wire logic [2:0]                   func,
	input  wire logic [$clog2(SLOTS)-1:0]     slot_index,
	input  wire logic [GEN_BITS-1:0]          handle_generation,
	input  wire logic [KIND_BITS-1:0]         kind_tag,
	output      logic                         rsp_valid,
	input  wire logic                         rsp_stall,
	output      logic [1:0]                   status,
	output      logic [$clog2(SLOTS)-1:0]     result_index,
	output      logic [GEN_BITS-1:0]          result_generation,
	output      logic [KIND_BITS-1:0]         stored_kind,
	output      logic [$clog2(SLOTS+1)-1:0]   live_count,
	output      logic [$clog2(SLOTS+1)-1:0]   high_water
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int MW = GEN_BITS + KIND_BITS;

	// slot state kept in flops
	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] gen_ok_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    high_q;

	// generation and kind memory
	logic [MW-1:0] mem [SLOTS];
	logic [MW-1:0] rd_q;

	// stage 1: accepted word
	logic            valid_s1;
	logic [2:0]      func_s1;
	logic [IW-1:0]   idx_s1;
	logic            in_range_s1;
	logic            full_s1;
	logic [GEN_BITS-1:0]  hgen_s1;
	logic [KIND_BITS-1:0] kind_s1;

	// output register
	logic                 rsp_valid_q;
	logic [1:0]           status_q;
	logic [IW-1:0]        r_idx_q;
	logic [GEN_BITS-1:0]  r_gen_q;
	logic [KIND_BITS-1:0] r_kind_q;

	logic          accept;
	logic          complete;
	logic [IW-1:0] free_idx;
	logic          full;
	logic [IW-1:0] rd_addr;
	logic          in_range;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		full     = 1'b1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = IW'(i);
				full     = 1'b0;
			end
		end
	end

	assign accept    = req_valid && !req_stall;
	assign req_stall = valid_s1;
	assign complete  = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign in_range  = ({1'b0, slot_index} < (IW + 1)'(SLOTS));
	assign rd_addr   = (func == FUNC_ALLOC) ? free_idx : slot_index;

	// memory read at acceptance
	always_ff @(posedge clk) begin
		if (accept && ((func == FUNC_ALLOC) || in_range)) begin
			rd_q <= mem[rd_addr];
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= func;
			idx_s1      <= rd_addr;
			in_range_s1 <= (func == FUNC_ALLOC) ? 1'b1 : in_range;
			full_s1     <= full;
			hgen_s1     <= handle_generation;
			kind_s1     <= kind_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (complete) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 evaluation
	logic [GEN_BITS-1:0]  cur_gen;
	logic [KIND_BITS-1:0] cur_kind;
	logic [GEN_BITS-1:0]  next_gen;
	logic                 live;
	logic                 do_alloc;
	logic                 do_free;
	logic                 do_clear;
	logic [CW-1:0]        idx_plus1;
	logic [1:0]           n_status;
	logic [IW-1:0]        n_idx;
	logic [GEN_BITS-1:0]  n_gen;
	logic [KIND_BITS-1:0] n_kind;

	always_comb begin
		cur_gen   = gen_ok_q[idx_s1] ? rd_q[GEN_BITS-1:0] : '0;
		cur_kind  = rd_q[MW-1:GEN_BITS];
		next_gen  = cur_gen + GEN_BITS'(1);
		live      = in_range_s1 && used_q[idx_s1] && (cur_gen == hgen_s1);
		idx_plus1 = CW'(idx_s1) + CW'(1);
		do_alloc  = (func_s1 == FUNC_ALLOC) && !full_s1;
		do_free   = (func_s1 == FUNC_FREE) && live;
		do_clear  = (func_s1 == FUNC_CLEAR);
		n_status  = STAT_OK;
		n_idx     = '0;
		n_gen     = '0;
		n_kind    = '0;
		unique case (func_s1)
			FUNC_ALLOC: begin
				if (full_s1) begin
					n_status = STAT_FULL;
				end else begin
					n_idx = idx_s1;
					n_gen = next_gen;
				end
			end
			FUNC_FREE: begin
				if (live) begin
					n_idx = idx_s1;
					n_gen = cur_gen;
				end else begin
					n_status = STAT_STALE;
				end
			end
			FUNC_VALIDATE: begin
				if (live) begin
					n_idx  = idx_s1;
					n_gen  = cur_gen;
					n_kind = cur_kind;
				end else begin
					n_status = STAT_STALE;
				end
			end
			FUNC_READ_GEN: begin
				if (in_range_s1) begin
					n_idx = idx_s1;
					n_gen = cur_gen;
				end else begin
					n_status = STAT_STALE;
				end
			end
			default: begin
				n_status = STAT_OK;
			end
		endcase
	end

	// write back on allocate
	always_ff @(posedge clk) begin
		if (complete && do_alloc) begin
			mem[idx_s1] <= {kind_s1, next_gen};
		end
	end

	// flop state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			gen_ok_q <= '0;
			count_q  <= '0;
			high_q   <= '0;
		end else if (complete) begin
			if (do_clear) begin
				used_q   <= '0;
				gen_ok_q <= '0;
				count_q  <= '0;
				high_q   <= '0;
			end else if (do_alloc) begin
				used_q[idx_s1]   <= 1'b1;
				gen_ok_q[idx_s1] <= 1'b1;
				count_q          <= count_q + CW'(1);
				if (idx_plus1 > high_q) begin
					high_q <= idx_plus1;
				end
			end else if (do_free) begin
				used_q[idx_s1] <= 1'b0;
				if (count_q != '0) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (complete) begin
			status_q <= n_status;
			r_idx_q  <= n_idx;
			r_gen_q  <= n_gen;
			r_kind_q <= n_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (complete) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// counts shown with the result are the ones after its operation
	logic [CW-1:0] count_out_q;
	logic [CW-1:0] high_out_q;

	always_ff @(posedge clk) begin
		if (complete) begin
			if (do_clear) begin
				count_out_q <= '0;
				high_out_q  <= '0;
			end else if (do_alloc) begin
				count_out_q <= count_q + CW'(1);
				high_out_q  <= (idx_plus1 > high_q) ? idx_plus1 : high_q;
			end else if (do_free && (count_q != '0)) begin
				count_out_q <= count_q - CW'(1);
				high_out_q  <= high_q;
			end else begin
				count_out_q <= count_q;
				high_out_q  <= high_q;
			end
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign status            = status_q;
	assign result_index      = r_idx_q;
	assign result_generation = r_gen_q;
	assign stored_kind       = r_kind_q;
	assign live_count        = count_out_q;
	assign high_water        = high_out_q;

endmodule

`default_nettype wire

@@ rtl/gsa_checker.sv @@
// Port-level checker for the generational slot allocator and its bind.
`default_nettype none

module gsa_checker
	import gsa_pkg::*;
#(
	parameter int SLOTS    = 64,
	parameter int GEN_BITS = 16
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_stall,
	input wire logic [2:0]                 func,
	input wire logic [$clog2(SLOTS)-1:0]   slot_index,
	input wire logic [GEN_BITS-1:0]        handle_generation,
	input wire logic [KIND_BITS-1:0]       kind_tag,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_stall,
	input wire logic [1:0]                 status,
	input wire logic [$clog2(SLOTS)-1:0]   result_index,
	input wire logic [GEN_BITS-1:0]        result_generation,
	input wire logic [KIND_BITS-1:0]       stored_kind,
	input wire logic [$clog2(SLOTS+1)-1:0] live_count,
	input wire logic [$clog2(SLOTS+1)-1:0] high_water
);

	localparam int CW = $clog2(SLOTS + 1);

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
		$stable(result_index) && $stable(result_generation) && $stable(stored_kind))
		else $error("stalled result word changed");

	// the live count never exceeds the high-water mark
	a_count_le_high: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> live_count <= high_water)
		else $error("live count above high-water mark");

	// full is reported only when every slot is taken
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_FULL) |-> live_count == CW'(SLOTS))
		else $error("full reported with free slots");

	// a failed operation carries zero fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != STAT_OK) |->
		(result_index == '0) && (result_generation == '0) && (stored_kind == '0))
		else $error("failed operation carries nonzero fields");

endmodule

bind generational_slot_allocator gsa_checker #(
	.SLOTS(SLOTS),
	.GEN_BITS(GEN_BITS)
) u_gsa_checker (.*);

`default_nettype wire
